/* rtl/bas_pkg.sv */
package bas_pkg;

    // Stream payload widths.
    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 1;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ARMS       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_EST   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIDENCE = 3'd4;

    // Request kinds.
    localparam logic [1:0] KIND_SELECT  = 2'd0;
    localparam logic [1:0] KIND_REWARD  = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    // Fixed point datapath widths.
    localparam int EST_W     = 32;
    localparam int CONF_W    = 16;
    localparam int LN_W      = 21;
    localparam int DIVN_W    = LN_W + 16;
    localparam int ROOT_W    = (DIVN_W + 1) / 2;
    localparam int LOG_STEPS = 16;

    localparam logic [15:0] LN2_Q16 = 16'd45426;

endpackage

/* rtl/bas_ram.sv */
module bas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/bas_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module bas_div #(
    parameter int NUM_W = 37,
    parameter int DEN_W = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int CW = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NUM_W);
                rem_reg  <= '0;
                quo_reg  <= dividend;
                den_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                quo_reg <= {quo_reg[NUM_W-2:0], fits};
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/bas_isqrt.sv */
// Floor square root, one result bit per cycle.
module bas_isqrt #(
    parameter int IN_W = 37
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [IN_W-1:0]         value,
    output logic                    done,
    output logic [(IN_W+1)/2-1:0]   root
);

    localparam int K  = (IN_W + 1) / 2;
    localparam int CW = $clog2(K + 1);

    logic           busy_reg;
    logic           done_reg;
    logic [CW-1:0]  cnt_reg;
    logic [2*K-1:0] val_reg;
    logic [K+1:0]   rem_reg;
    logic [K-1:0]   root_reg;
    logic [K+3:0]   rem_sh;
    logic [K+3:0]   trial;
    logic           fits;

    assign rem_sh = {rem_reg, val_reg[2*K-1:2*K-2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(K);
                val_reg  <= (2*K)'(value);
                rem_reg  <= '0;
                root_reg <= '0;
            end else if (busy_reg) begin
                rem_reg  <= fits ? (K+2)'(rem_sh - trial) : (K+2)'(rem_sh);
                root_reg <= {root_reg[K-2:0], fits};
                val_reg  <= {val_reg[2*K-3:0], 2'b00};
                cnt_reg  <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

/* rtl/bas_ln.sv */
// Natural log in Q5.16: binary log by repeated squaring, then times ln2.
module bas_ln (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [31:0]             value,
    output logic                    done,
    output logic [bas_pkg::LN_W-1:0] ln
);

    import bas_pkg::*;

    logic        busy_reg;
    logic        mul_reg;
    logic        done_reg;
    logic        zero_reg;
    logic [4:0]  cnt_reg;
    logic [4:0]  ip_reg;
    logic [15:0] frac_reg;
    logic [31:0] m_reg;
    logic [36:0] prod_reg;
    logic [4:0]  ip_c;
    logic [63:0] sq;
    logic [32:0] sh;

    always_comb begin
        ip_c = '0;
        for (int i = 0; i < 32; i++) begin
            if (value[i]) begin
                ip_c = 5'(i);
            end
        end
    end

    assign sq = {32'b0, m_reg} * {32'b0, m_reg};
    assign sh = sq[63:31];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            mul_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(LOG_STEPS);
                m_reg    <= value << (5'd31 - ip_c);
                ip_reg   <= ip_c;
                frac_reg <= '0;
                zero_reg <= (value == 32'd0);
            end else if (busy_reg) begin
                if (sh[32]) begin
                    m_reg    <= sh[32:1];
                    frac_reg <= {frac_reg[14:0], 1'b1};
                end else begin
                    m_reg    <= sh[31:0];
                    frac_reg <= {frac_reg[14:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1) begin
                    busy_reg <= 1'b0;
                    mul_reg  <= 1'b1;
                end
            end else if (mul_reg) begin
                prod_reg <= {16'b0, ip_reg, frac_reg} * {21'b0, LN2_Q16};
                mul_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign ln   = zero_reg ? '0 : prod_reg[36:16];

endmodule

/* rtl/bandit_arm_selector_core.sv */
// Channel   | Direction | Handshake          | Payload
// s_ (in)   | input     | s_tvalid/s_tready  | s_tuser kind, s_tdata arm/reward/draws
// m_ (out)  | output    | m_tvalid/m_tready  | m_tuser explored, m_tdata arm/estimate/sat
// cfg_wr_   | input     | cfg_wr_en          | cfg_wr_addr register, cfg_wr_data value
//
// One request is processed at a time. A reward passes through the shared
// divider, an epsilon-greedy select scans every arm in use, an exploring
// pick takes its modulo by repeated subtraction, and a UCB select passes
// each visited arm in turn through the divider and square root unit,
// stopping at the first unvisited arm.
// Reset (synchronous, active low) clears all counts at once through valid
// bits; the estimate memory is never cleared. A finished result waits in the
// output register while the next request is already accepted.
module bandit_arm_selector_core #(
    parameter int NUM_ARMS    = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // kind[1:0]
    input  logic [bas_pkg::S_TUSER_W-1:0]   s_tuser,
    // arm[3:0], reward[35:4], greedy_draw[51:36], random_arm[55:52]
    input  logic [bas_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // explored[0]
    output logic [bas_pkg::M_TUSER_W-1:0]   m_tuser,
    // chosen_arm[3:0], estimate_out[35:4], count_saturated[36], zero[39:37]
    output logic [bas_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_wr_en,
    input  logic [bas_pkg::CFG_IDX_W-1:0]   cfg_wr_addr,
    input  logic [bas_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);

    import bas_pkg::*;

    localparam int AW     = $clog2(NUM_ARMS);
    localparam int NW     = $clog2(NUM_ARMS + 1);
    localparam int LW     = (NW > 5) ? NW : 5;
    localparam int CW     = COUNT_WIDTH;
    localparam int PROD_W = ROOT_W + CONF_W;

    typedef enum logic [13:0] {
        ST_IDLE      = 14'h0001,
        ST_REW_WAIT  = 14'h0002,
        ST_REW_CALC  = 14'h0004,
        ST_REW_DIV   = 14'h0008,
        ST_MOD       = 14'h0010,
        ST_SCAN_WAIT = 14'h0020,
        ST_SCAN_CHK  = 14'h0040,
        ST_LN        = 14'h0080,
        ST_UCB_WAIT  = 14'h0100,
        ST_UCB_CHK   = 14'h0200,
        ST_UCB_DIV   = 14'h0400,
        ST_UCB_SQRT  = 14'h0800,
        ST_UCB_CMP   = 14'h1000,
        ST_DONE      = 14'h2000
    } state_t;

    localparam logic [CW-1:0] CMAX = {CW{1'b1}};

    // Configuration registers.
    logic              mode_reg;
    logic [4:0]        arms_reg;
    logic [16:0]       thr_reg;
    logic [EST_W-1:0]  init_reg;
    logic [CONF_W-1:0] conf_reg;

    // Control and working state.
    state_t                state_reg;
    logic [AW-1:0]         idx_reg;
    logic [LW-1:0]         mod_reg;
    logic                  explore_reg;
    logic [NUM_ARMS-1:0]   valid_reg;
    logic [CW-1:0]         total_reg;
    logic [EST_W-1:0]      reward_reg;
    logic [EST_W-1:0]      e_reg;
    logic [CW-1:0]         c_reg;
    logic                  neg_reg;
    logic [LN_W-1:0]       ln_reg;
    logic signed [EST_W-1:0] est_a_reg;
    logic                  sat_a_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic signed [33:0]    top_reg;

    // Result being built, and the output register.
    logic [3:0]              res_arm_reg;
    logic                    res_expl_reg;
    logic signed [EST_W-1:0] res_est_reg;
    logic                    res_sat_reg;
    logic                    m_valid_reg;
    logic [3:0]              out_arm_reg;
    logic                    out_expl_reg;
    logic [EST_W-1:0]        out_est_reg;
    logic                    out_sat_reg;

    // Request fields.
    logic [1:0]       in_kind;
    logic [3:0]       in_arm;
    logic [EST_W-1:0] in_reward;
    logic [15:0]      in_draw;
    logic [3:0]       in_rarm;

    assign in_kind   = s_tuser;
    assign in_arm    = s_tdata[3:0];
    assign in_reward = s_tdata[35:4];
    assign in_draw   = s_tdata[51:36];
    assign in_rarm   = s_tdata[55:52];

    // Arms in use, clamped to the range 1 to NUM_ARMS.
    logic [LW-1:0] arms_ext;
    logic [LW-1:0] n_live;
    logic [LW-1:0] idx_ext;
    logic [LW-1:0] in_arm_ext;
    logic          idx_last;

    assign arms_ext   = LW'(arms_reg);
    assign n_live     = (arms_ext == '0) ? LW'(1) :
                        (arms_ext > LW'(NUM_ARMS)) ? LW'(NUM_ARMS) : arms_ext;
    assign idx_ext    = LW'(idx_reg);
    assign in_arm_ext = LW'(in_arm);
    assign idx_last   = (idx_ext == n_live - LW'(1));

    logic accept;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Memories: estimate and pull count per arm. Counts of arms whose valid
    // bit is clear read as zero, which also covers restart.
    logic [EST_W-1:0] est_rd;
    logic [CW-1:0]    cnt_rd;
    logic             mem_we;
    logic [EST_W-1:0] est_wdata;
    logic             arm_valid;

    assign arm_valid = valid_reg[idx_reg];

    bas_ram #(.WIDTH(EST_W), .DEPTH(NUM_ARMS)) u_est_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (idx_reg),
        .wdata (est_wdata),
        .raddr (idx_reg),
        .rdata (est_rd)
    );

    bas_ram #(.WIDTH(CW), .DEPTH(NUM_ARMS)) u_cnt_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (idx_reg),
        .wdata (c_reg),
        .raddr (idx_reg),
        .rdata (cnt_rd)
    );

    // Reward update arithmetic.
    logic signed [EST_W-1:0] e_now;
    logic [CW-1:0]           cnt_now;
    logic [CW-1:0]           c_now;
    logic [32:0]             diff;
    logic [32:0]             mag;
    logic [32:0]             q33;
    logic [33:0]             qs;
    logic [33:0]             nv34;

    assign e_now   = arm_valid ? est_rd : init_reg;
    assign cnt_now = arm_valid ? cnt_rd : '0;
    assign c_now   = (cnt_now == CMAX) ? cnt_now : cnt_now + CW'(1);
    assign diff    = {reward_reg[31], reward_reg} - {e_now[31], e_now};
    assign mag     = diff[32] ? (~diff + 33'd1) : diff;

    // Shared divider: reward step size, or ln(total) / count for UCB.
    logic              div_start;
    logic [DIVN_W-1:0] div_num;
    logic              div_done;
    logic [DIVN_W-1:0] div_quo;

    assign div_start = (state_reg == ST_REW_CALC) ||
                       (state_reg == ST_UCB_CHK && arm_valid);
    assign div_num   = (state_reg == ST_REW_CALC) ? DIVN_W'(mag) : {ln_reg, 16'b0};

    bas_div #(.NUM_W(DIVN_W), .DEN_W(CW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  ((state_reg == ST_REW_CALC) ? c_now : cnt_rd),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign q33       = div_quo[32:0];
    assign qs        = neg_reg ? (34'd0 - {1'b0, q33}) : {1'b0, q33};
    assign nv34      = {{2{e_reg[31]}}, e_reg} + qs;
    assign est_wdata = nv34[31:0];
    assign mem_we    = (state_reg == ST_REW_DIV) && div_done;

    // Square root of the ratio, and the log of the total pull count.
    logic              sqrt_done;
    logic [ROOT_W-1:0] root;
    logic              ln_done;
    logic [LN_W-1:0]   ln_out;

    bas_isqrt #(.IN_W(DIVN_W)) u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   ((state_reg == ST_UCB_DIV) && div_done),
        .value   (div_quo),
        .done    (sqrt_done),
        .root    (root)
    );

    bas_ln u_ln (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept && in_kind == KIND_SELECT && mode_reg),
        .value   (32'(total_reg)),
        .done    (ln_done),
        .ln      (ln_out)
    );

    // Per arm comparisons.
    logic signed [EST_W-1:0] scan_est;
    logic                    scan_sat;
    logic                    scan_take;
    logic signed [33:0]      score;

    assign scan_est  = arm_valid ? est_rd : init_reg;
    assign scan_sat  = arm_valid && (cnt_rd == CMAX);
    assign scan_take = explore_reg || (idx_reg == '0) || (scan_est > res_est_reg);
    assign score     = {{2{est_a_reg[31]}}, est_a_reg} +
                       {7'b0, prod_reg[PROD_W-1:8]};

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
            arms_reg <= 5'd16;
            thr_reg  <= 17'd58982;
            init_reg <= '0;
            conf_reg <= 16'd512;
        end else if (cfg_wr_en) begin
            case (cfg_wr_addr)
                CFG_MODE:       mode_reg <= cfg_wr_data[0];
                CFG_ARMS:       arms_reg <= cfg_wr_data[4:0];
                CFG_THRESHOLD:  thr_reg  <= cfg_wr_data[16:0];
                CFG_INIT_EST:   init_reg <= cfg_wr_data;
                CFG_CONFIDENCE: conf_reg <= cfg_wr_data[15:0];
                default: ;
            endcase
        end
    end

    // Main sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // In ST_DONE the output register is reloaded instead.
            if (m_valid_reg && m_tready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        res_arm_reg  <= (in_kind == KIND_REWARD) ? in_arm : '0;
                        res_expl_reg <= 1'b0;
                        res_est_reg  <= '0;
                        res_sat_reg  <= 1'b0;
                        case (in_kind)
                            KIND_REWARD: begin
                                reward_reg  <= in_reward;
                                if (in_arm_ext >= n_live) begin
                                    state_reg <= ST_DONE;
                                end else begin
                                    idx_reg   <= in_arm_ext[AW-1:0];
                                    state_reg <= ST_REW_WAIT;
                                end
                            end
                            KIND_SELECT: begin
                                if (mode_reg) begin
                                    state_reg <= ST_LN;
                                end else if ({1'b0, in_draw} < thr_reg) begin
                                    idx_reg     <= '0;
                                    explore_reg <= 1'b0;
                                    state_reg   <= ST_SCAN_WAIT;
                                end else begin
                                    mod_reg     <= LW'(in_rarm);
                                    explore_reg <= 1'b1;
                                    state_reg   <= ST_MOD;
                                end
                            end
                            KIND_RESTART: begin
                                valid_reg <= '0;
                                total_reg <= '0;
                                state_reg <= ST_DONE;
                            end
                            default: begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_REW_WAIT: begin
                    state_reg <= ST_REW_CALC;
                end
                ST_REW_CALC: begin
                    e_reg     <= e_now;
                    c_reg     <= c_now;
                    neg_reg   <= diff[32];
                    state_reg <= ST_REW_DIV;
                end
                ST_REW_DIV: begin
                    if (div_done) begin
                        valid_reg[idx_reg] <= 1'b1;
                        if (total_reg != CMAX) begin
                            total_reg <= total_reg + CW'(1);
                        end
                        res_est_reg <= est_wdata;
                        res_sat_reg <= (c_reg == CMAX);
                        state_reg   <= ST_DONE;
                    end
                end
                ST_MOD: begin
                    if (mod_reg >= n_live) begin
                        mod_reg <= mod_reg - n_live;
                    end else begin
                        idx_reg   <= mod_reg[AW-1:0];
                        state_reg <= ST_SCAN_WAIT;
                    end
                end
                ST_SCAN_WAIT: begin
                    state_reg <= ST_SCAN_CHK;
                end
                ST_SCAN_CHK: begin
                    if (scan_take) begin
                        res_arm_reg  <= idx_ext[3:0];
                        res_est_reg  <= scan_est;
                        res_sat_reg  <= scan_sat;
                        res_expl_reg <= explore_reg;
                    end
                    if (explore_reg || idx_last) begin
                        state_reg <= ST_DONE;
                    end else begin
                        idx_reg   <= idx_reg + AW'(1);
                        state_reg <= ST_SCAN_WAIT;
                    end
                end
                ST_LN: begin
                    if (ln_done) begin
                        ln_reg    <= ln_out;
                        idx_reg   <= '0;
                        state_reg <= ST_UCB_WAIT;
                    end
                end
                ST_UCB_WAIT: begin
                    state_reg <= ST_UCB_CHK;
                end
                ST_UCB_CHK: begin
                    if (!arm_valid) begin
                        // An unvisited arm wins at once.
                        res_arm_reg <= idx_ext[3:0];
                        res_est_reg <= init_reg;
                        res_sat_reg <= 1'b0;
                        state_reg   <= ST_DONE;
                    end else begin
                        est_a_reg <= est_rd;
                        sat_a_reg <= (cnt_rd == CMAX);
                        state_reg <= ST_UCB_DIV;
                    end
                end
                ST_UCB_DIV: begin
                    if (div_done) begin
                        state_reg <= ST_UCB_SQRT;
                    end
                end
                ST_UCB_SQRT: begin
                    if (sqrt_done) begin
                        prod_reg  <= {{CONF_W{1'b0}}, root} * {{ROOT_W{1'b0}}, conf_reg};
                        state_reg <= ST_UCB_CMP;
                    end
                end
                ST_UCB_CMP: begin
                    if (idx_reg == '0 || score > top_reg) begin
                        top_reg     <= score;
                        res_arm_reg <= idx_ext[3:0];
                        res_est_reg <= est_a_reg;
                        res_sat_reg <= sat_a_reg;
                    end
                    if (idx_last) begin
                        state_reg <= ST_DONE;
                    end else begin
                        idx_reg   <= idx_reg + AW'(1);
                        state_reg <= ST_UCB_WAIT;
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg  <= 1'b1;
                        out_arm_reg  <= res_arm_reg;
                        out_expl_reg <= res_expl_reg;
                        out_est_reg  <= res_est_reg;
                        out_sat_reg  <= res_sat_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_expl_reg;
    assign m_tdata  = {3'b000, out_sat_reg, out_est_reg, out_arm_reg};

    // A zero total means no arm has ever been counted since reset or restart.
    ap_total_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (total_reg == '0) |-> (valid_reg == '0))
        else $error("valid arm present while total pull count is zero");

    // Only one request is in work at a time.
    ap_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in work");

    // Arm walks never leave the arms in use.
    ap_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN_CHK || state_reg == ST_UCB_CHK) |-> (idx_ext < n_live))
        else $error("arm index beyond arms in use");

endmodule

/* verif/bandit_arm_selector_checker.sv */
module bandit_arm_selector_checker
    import bas_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_TUSER_W-1:0]   s_tuser,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_TUSER_W-1:0]   m_tuser,
    input  logic [M_TDATA_W-1:0]   m_tdata,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_wr_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    output int                     mismatches,
    output int                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ARMS = 16;
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [3:0]  arm;
        logic        explored;
        logic [31:0] estimate;
        logic        saturated;
    } choice_t;

    // Learner state and registers as seen from the ports.
    logic        sel_ucb;
    logic [4:0]  arms_reg;
    logic [16:0] threshold;
    longint      init_est;
    logic [15:0] ucb_weight;
    longint      arm_value [ARMS];
    logic [31:0] pulls [ARMS];
    logic [31:0] total;

    choice_t expected_choices[$];

    function automatic longint value_of(int a);
        return (pulls[a] == 0) ? init_est : arm_value[a];
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned res = 0;
        longint unsigned bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Natural log in Q5.16: binary log by repeated squaring, times ln2.
    function automatic longint unsigned log_nat_q16(logic [31:0] t);
        int ip = 0;
        longint unsigned m;
        longint unsigned frac = 0;
        while (ip < 31 && (t >> (ip + 1)) != 0) ip++;
        m = ({32'b0, t} << (31 - ip)) & 64'hFFFF_FFFF;
        for (int i = 0; i < LOG_STEPS; i++) begin
            m = (m * m) >> 31;
            frac <<= 1;
            if (m >= 64'h1_0000_0000) begin
                m >>= 1;
                frac |= 1;
            end
        end
        return (((longint'(ip) << 16) | frac) * LN2_Q16) >> 16;
    endfunction

    function automatic choice_t learn_step(logic [1:0] kind, logic [3:0] arm,
                                           logic [31:0] reward, logic [15:0] draw,
                                           logic [3:0] rarm);
        choice_t c = '0;
        int n = (arms_reg < 1) ? 1 : ((arms_reg > ARMS) ? ARMS : int'(arms_reg));
        int best = 0;
        bit found = 0;
        longint e, nv, score, top;
        longint unsigned lnv, ratio, bonus;
        logic [31:0] cnt;
        if (kind == KIND_REWARD) begin
            c.arm = arm;
            if (arm >= n) return c;
            e = value_of(arm);
            cnt = pulls[arm];
            if (cnt < COUNT_MAX) cnt++;
            pulls[arm] = cnt;
            if (total < COUNT_MAX) total++;
            nv = e + (longint'(signed'(reward)) - e) / longint'({32'b0, cnt});
            arm_value[arm] = nv;
            c.estimate = nv[31:0];
            c.saturated = (cnt == COUNT_MAX);
            return c;
        end
        if (kind != KIND_SELECT) begin
            if (kind == KIND_RESTART) begin
                foreach (pulls[i]) pulls[i] = '0;
                total = '0;
            end
            return c;
        end
        if (!sel_ucb) begin
            if ({1'b0, draw} < threshold) begin
                for (int a = 1; a < n; a++)
                    if (value_of(a) > value_of(best)) best = a;
            end else begin
                best = int'(rarm) % n;
                c.explored = 1'b1;
            end
        end else begin
            for (int a = 0; a < n && !found; a++)
                if (pulls[a] == 0) begin
                    best = a;
                    found = 1;
                end
            if (!found) begin
                lnv = (total == 0) ? 0 : log_nat_q16(total);
                top = 0;
                for (int a = 0; a < n; a++) begin
                    ratio = (lnv << 16) / {32'b0, pulls[a]};
                    bonus = (floor_sqrt(ratio) * ucb_weight) >> 8;
                    score = arm_value[a] + longint'(bonus);
                    if (a == 0 || score > top) begin
                        top = score;
                        best = a;
                    end
                end
            end
        end
        c.arm = best[3:0];
        e = value_of(best);
        c.estimate = e[31:0];
        c.saturated = (pulls[best] == COUNT_MAX);
        return c;
    endfunction

    choice_t got, want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            sel_ucb <= 1'b0;
            arms_reg <= 5'd16;
            threshold <= 17'd58982;
            init_est <= 0;
            ucb_weight <= 16'd512;
            foreach (pulls[i]) begin
                pulls[i] = '0;
                arm_value[i] = 0;
            end
            total = '0;
            mismatches <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_addr)
                    CFG_MODE:       sel_ucb <= cfg_wr_data[0];
                    CFG_ARMS:       arms_reg <= cfg_wr_data[4:0];
                    CFG_THRESHOLD:  threshold <= cfg_wr_data[16:0];
                    CFG_INIT_EST:   init_est <= longint'(signed'(cfg_wr_data));
                    CFG_CONFIDENCE: ucb_weight <= cfg_wr_data[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_choices.push_back(learn_step(s_tuser[1:0], s_tdata[3:0],
                    s_tdata[35:4], s_tdata[51:36], s_tdata[55:52]));
            if (m_tvalid && m_tready) begin
                got = {m_tdata[3:0], m_tuser[0], m_tdata[35:4], m_tdata[36]};
                if (expected_choices.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result arm=%0d est=%h", $realtime,
                                 got.arm, got.estimate);
                    mismatches <= mismatches + 1;
                end else begin
                    want = expected_choices.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10)
                            $display({"%0t: result mismatch: expected arm=%0d expl=%0d ",
                                      "est=%h sat=%0d, got arm=%0d expl=%0d est=%h sat=%0d"},
                                     $realtime, want.arm, want.explored, want.estimate,
                                     want.saturated, got.arm, got.explored, got.estimate,
                                     got.saturated);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end

    assign pending = expected_choices.size();

endmodule

/* verif/bandit_arm_selector_core_tb.sv */
module bandit_arm_selector_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bas_pkg::*;

    // This limit leaves several times the slowest plausible run of about
    // 660 requests.
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int RANDOM_PER_PHASE = 128;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TUSER_W-1:0]  s_tuser = '0;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    int mismatches;
    int pending;

    // Idling percentages of the current phase, and the long receiver hold-off.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_req = 1'b0;
    bit   hold_done = 0;
    int   hold_left = 0;
    int   live_n = 16;
    longint cycles = 0;

    always #2 aclk = ~aclk;

    bandit_arm_selector_core u_dut (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tuser, .s_tdata,
        .m_tvalid, .m_tready, .m_tuser, .m_tdata,
        .cfg_wr_en, .cfg_wr_addr, .cfg_wr_data
    );

    bandit_arm_selector_checker u_checker (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tuser, .s_tdata,
        .m_tvalid, .m_tready, .m_tuser, .m_tdata,
        .cfg_wr_en, .cfg_wr_addr, .cfg_wr_data,
        .mismatches, .pending
    );

    // Receiver: random stalls per phase, plus one long hold-off on request so
    // the output register fills and the block stops taking requests.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_tready <= 1'b0;
            hold_left <= 400;
            hold_done <= 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[bandit_arm_selector_core] ERROR");
            $finish;
        end
    end

    // Offers one request and holds it until the block takes it. Valid stays
    // high afterwards so back-to-back requests follow without a gap.
    task automatic send_request(logic [1:0] kind, logic [3:0] arm, logic [31:0] reward,
                                logic [15:0] draw, logic [3:0] rarm);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {rarm, draw, reward, arm};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Waits until every outstanding request has produced its result.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_addr <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
    endtask

    // Reprograms every register; only called while the block is idle.
    task automatic configure(logic ucb, logic [4:0] arms, logic [16:0] thr,
                             logic [31:0] init, logic [15:0] conf);
        write_reg(CFG_MODE, {31'b0, ucb});
        write_reg(CFG_ARMS, {27'b0, arms});
        write_reg(CFG_THRESHOLD, {15'b0, thr});
        write_reg(CFG_INIT_EST, init);
        write_reg(CFG_CONFIDENCE, {16'b0, conf});
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        live_n = (arms == 0) ? 1 : ((arms > 16) ? 16 : int'(arms));
    endtask

    // Random request mix: mostly selects and in-range rewards with small
    // values, so the estimates move in interesting ways, plus restarts,
    // the unused kind, out-of-range arms and full-range rewards.
    task automatic random_requests(int count);
        int pick;
        logic [1:0] kind;
        logic [3:0] arm;
        logic [31:0] reward;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            kind = (pick < 45) ? KIND_SELECT : (pick < 88) ? KIND_REWARD :
                   (pick < 94) ? KIND_RESTART : 2'd3;
            arm = ($urandom_range(99) < 85) ? 4'($urandom_range(live_n - 1))
                                            : 4'($urandom_range(15));
            if ($urandom_range(99) < 20)
                reward = $urandom;
            else
                reward = 32'($urandom_range(8 << 16)) - 32'(4 << 16);
            send_request(kind, arm, reward, 16'($urandom), 4'($urandom));
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: greedy over fresh arms, exploring pick, extreme rewards,
        // restart, the unused kind with every data bit set.
        configure(1'b0, 5'd16, 17'd58982, 32'h0, 16'd512);
        send_request(KIND_SELECT, 4'd0, 32'h0, 16'h0000, 4'd0);
        send_request(KIND_SELECT, 4'd0, 32'h0, 16'hFFFF, 4'd15);
        send_request(KIND_REWARD, 4'd0, 32'h7FFF_FFFF, 16'h0, 4'd0);
        send_request(KIND_REWARD, 4'd15, 32'h8000_0000, 16'h0, 4'd0);
        send_request(KIND_REWARD, 4'd3, 32'h0, 16'h0, 4'd0);
        send_request(KIND_REWARD, 4'd0, 32'h8000_0000, 16'h0, 4'd0);
        send_request(KIND_REWARD, 4'd0, 32'h7FFF_FFFF, 16'h0, 4'd0);
        send_request(KIND_SELECT, 4'd0, 32'h0, 16'h0000, 4'd0);
        send_request(KIND_SELECT, 4'd0, 32'h0, 16'hFFFF, 4'd0);
        send_request(KIND_RESTART, 4'd0, 32'h0, 16'h0, 4'd0);
        send_request(2'd3, 4'hF, 32'hFFFF_FFFF, 16'hFFFF, 4'hF);
        send_request(KIND_SELECT, 4'd0, 32'h0, 16'h0000, 4'd0);
        random_requests(RANDOM_PER_PHASE);
        drain_results();

        // Zero arms acts as one, always greedy, most negative start value.
        send_idle_pct = 48;
        configure(1'b0, 5'd0, 17'd65536, 32'h8000_0000, 16'd0);
        send_request(KIND_REWARD, 4'd1, 32'h1234_5678, 16'h0, 4'd0);
        send_request(KIND_SELECT, 4'd0, 32'h0, 16'hFFFF, 4'd15);
        random_requests(RANDOM_PER_PHASE / 2);
        // The sender pauses until every result is back, then goes on.
        drain_results();
        random_requests(RANDOM_PER_PHASE / 2);
        drain_results();

        // UCB over four arms, unvisited arms first, then the bound itself.
        send_idle_pct = 0;
        recv_stall_pct = 48;
        configure(1'b1, 5'd4, 17'd0, 32'h7FFF_FFFF, 16'd65535);
        send_request(KIND_SELECT, 4'd0, 32'h0, 16'h0, 4'd0);
        send_request(KIND_REWARD, 4'd15, 32'h0001_0000, 16'h0, 4'd0);
        for (int a = 0; a < 4; a++)
            send_request(KIND_REWARD, 4'(a), 32'(a << 16), 16'h0, 4'd0);
        send_request(KIND_SELECT, 4'd0, 32'h0, 16'h0, 4'd0);
        random_requests(RANDOM_PER_PHASE);
        drain_results();

        // UCB with an oversized arm count, which acts as all sixteen.
        send_idle_pct = 29;
        recv_stall_pct = 29;
        configure(1'b1, 5'd31, 17'd32768, 32'hFFFF_0000, 16'd512);
        random_requests(RANDOM_PER_PHASE);
        drain_results();

        // Greedy-off epsilon mode over five arms, full speed, with one long
        // receiver hold-off while requests keep coming.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        configure(1'b0, 5'd5, 17'd0, 32'd12345, 16'd256);
        hold_req <= 1'b1;
        random_requests(RANDOM_PER_PHASE);
        drain_results();
        repeat (50) @(posedge aclk);

        if (mismatches == 0 && pending == 0) begin
            $display("[bandit_arm_selector_core] OK");
        end else begin
            $display("[bandit_arm_selector_core] ERROR");
        end
        $finish;
    end

endmodule

/* bandit_arm_selector_core.f */
rtl/bas_pkg.sv
rtl/bas_ram.sv
rtl/bas_div.sv
rtl/bas_isqrt.sv
rtl/bas_ln.sv
rtl/bandit_arm_selector_core.sv
verif/bandit_arm_selector_checker.sv
verif/bandit_arm_selector_core_tb.sv
